// ===== rtl/gpib_pkg.sv =====
package gpib_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int MAX_GUTTER = 3;

  localparam int DIM_W  = $clog2(MAX_DIM) + 1;
  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int GUT_W  = 2;
  localparam int SPAN_W = $clog2(2 * MAX_GUTTER + 1);
  localparam int ADDR_W = 24;
  localparam int PIX_W  = 32;
  localparam int IDX_W  = 3;
  localparam int OUT_W  = ADDR_W + PIX_W;

  typedef enum logic [IDX_W-1:0] {
    REG_DEST_WIDTH = 3'd0,
    REG_PLACE_X    = 3'd1,
    REG_PLACE_Y    = 3'd2,
    REG_GUTTER     = 3'd3,
    REG_SRC_WIDTH  = 3'd4,
    REG_SRC_HEIGHT = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic add;
    logic next_col;
    logic next_row;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic col_done;
    logic row_done;
  } sts_t;

  // zero acts as one, oversized acts as the maximum
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

  // gutter above the limit acts as the limit
  function automatic logic [GUT_W-1:0] eff_gut(input logic [GUT_W-1:0] v);
    logic [GUT_W-1:0] r;
    r = v;
    if (v > GUT_W'(MAX_GUTTER)) r = GUT_W'(MAX_GUTTER);
    return r;
  endfunction

endpackage

// ===== rtl/gpib_ctrl.sv =====
module gpib_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  gpib_pkg::sts_t sts,
  output gpib_pkg::cmd_t cmd
);
  import gpib_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (!sts.col_done) begin
            cmd.next_col = 1'b1;
          end else if (!sts.row_done) begin
            cmd.next_row = 1'b1;
            state_next   = ST_MUL;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a write is pending");

  a_accept_mul: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == ST_MUL)
    else $error("accepted item did not start a row");

  a_add_emit: assert property (@(posedge clk) disable iff (rst)
    state == ST_ADD |=> m_tvalid)
    else $error("row address ready but no write shown");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && sts.col_done && sts.row_done) |=> s_tready)
    else $error("group finished but block not ready");

endmodule

// ===== rtl/gpib_datapath.sv =====
module gpib_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gpib_pkg::IDX_W-1:0]    cfg_index,
  input  logic [gpib_pkg::DIM_W-1:0]    cfg_data,
  input  logic [gpib_pkg::PIX_W-1:0]    pixel,
  input  logic                          first,
  input  gpib_pkg::cmd_t                cmd,
  output gpib_pkg::sts_t                sts,
  output logic [gpib_pkg::ADDR_W-1:0]   address,
  output logic [gpib_pkg::PIX_W-1:0]    value,
  output logic                          last
);
  import gpib_pkg::*;

  logic [DIM_W-1:0] dest_width;
  logic [CNT_W-1:0] place_x;
  logic [CNT_W-1:0] place_y;
  logic [GUT_W-1:0] gutter;
  logic [DIM_W-1:0] src_width;
  logic [DIM_W-1:0] src_height;

  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;

  logic [ADDR_W-1:0] yrow;
  logic [ADDR_W-1:0] colbase;
  logic [ADDR_W-1:0] prod;
  logic [SPAN_W-1:0] nrows_m1, ncols_m1;
  logic [SPAN_W-1:0] row_i, col_i;

  logic [DIM_W-1:0] w, h;
  logic [GUT_W-1:0] g;
  logic [CNT_W-1:0] c_cur, r_cur;
  logic [DIM_W-1:0] c_inc, r_inc;
  logic             first_row, first_col, last_row, last_col;
  logic [ADDR_W-1:0] yrow_start, col_start;
  logic [SPAN_W-1:0] nrows_start, ncols_start;
  logic [ADDR_W+DIM_W-1:0] mul_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_width <= DIM_W'(MAX_DIM);
      place_x    <= '0;
      place_y    <= '0;
      gutter     <= '0;
      src_width  <= DIM_W'(1);
      src_height <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEST_WIDTH: dest_width <= cfg_data;
        REG_PLACE_X:    place_x    <= cfg_data[CNT_W-1:0];
        REG_PLACE_Y:    place_y    <= cfg_data[CNT_W-1:0];
        REG_GUTTER:     gutter     <= cfg_data[GUT_W-1:0];
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w     = eff_dim(src_width);
    h     = eff_dim(src_height);
    g     = eff_gut(gutter);
    c_cur = first ? '0 : column_count;
    r_cur = first ? '0 : row_count;
    c_inc = {1'b0, c_cur} + DIM_W'(1);
    r_inc = {1'b0, r_cur} + DIM_W'(1);
    first_row = (r_cur == '0);
    first_col = (c_cur == '0);
    // a counter past a shrunk size counts as on the last edge
    last_row  = (r_inc >= h);
    last_col  = (c_inc >= w);
    yrow_start = ADDR_W'(place_y) + ADDR_W'(r_cur)
                 - (first_row ? ADDR_W'(g) : '0);
    col_start  = ADDR_W'(place_x) + ADDR_W'(c_cur)
                 - (first_col ? ADDR_W'(g) : '0);
    nrows_start = (first_row ? SPAN_W'(g) : '0) + (last_row ? SPAN_W'(g) : '0);
    ncols_start = (first_col ? SPAN_W'(g) : '0) + (last_col ? SPAN_W'(g) : '0);
    mul_full = yrow * dest_width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.load) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= (r_inc >= h) ? '0 : r_inc[CNT_W-1:0];
      end else begin
        column_count <= c_inc[CNT_W-1:0];
        row_count    <= r_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value    <= pixel;
      yrow     <= yrow_start;
      colbase  <= col_start;
      nrows_m1 <= nrows_start;
      ncols_m1 <= ncols_start;
      row_i    <= '0;
    end
    if (cmd.mul) begin
      prod <= mul_full[ADDR_W-1:0];
    end
    if (cmd.add) begin
      address <= prod + colbase;
      col_i   <= '0;
    end
    if (cmd.next_col) begin
      address <= address + ADDR_W'(1);
      col_i   <= col_i + SPAN_W'(1);
    end
    if (cmd.next_row) begin
      yrow  <= yrow + ADDR_W'(1);
      row_i <= row_i + SPAN_W'(1);
    end
  end

  assign sts.col_done = (col_i == ncols_m1);
  assign sts.row_done = (row_i == nrows_m1);
  assign last         = sts.col_done && sts.row_done;

endmodule

// ===== rtl/gutter_padded_image_blit.sv =====
// channel   direction  contents
// s_*       in         tdata: pixel[31:0]; tuser: first
// m_*       out        tdata: address[23:0], value[55:24]; tlast: last
// cfg_*     in         write enable, register index, 13-bit data
//
// an item is accepted in the idle state; each destination row then passes through
// a multiply state and an add state before its writes, which within a row go out
// one per cycle. a stalled sink holds the write.
// synchronous reset clears the counters and the controller and returns the configuration registers to their defaults.
module gutter_padded_image_blit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // pixel
  input  logic        s_tuser,    // first
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,    // address, value
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [gpib_pkg::IDX_W-1:0] cfg_index,
  input  logic [gpib_pkg::DIM_W-1:0] cfg_data
);
  import gpib_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [ADDR_W-1:0] address;
  logic [PIX_W-1:0]  value;

  gpib_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gpib_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (s_tdata),
    .first     (s_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .address   (address),
    .value     (value),
    .last      (m_tlast)
  );

  assign m_tdata = {value, address};

endmodule
